[rtl/core/multiformat_sample_gain_saturate_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sample gain block
// Shorthand for clocked, reset-qualified properties on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTIFORMAT_SAMPLE_GAIN_SATURATE_TOP_ASSERT_SVH
`define MULTIFORMAT_SAMPLE_GAIN_SATURATE_TOP_ASSERT_SVH

// a holds -> b holds in the same cycle
`define ASSERT_IMPLIES(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("%m: assertion failed");

// a holds -> b holds in the next cycle
`define ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("%m: assertion failed");

// a holds -> b holds after the ##n delay
`define ASSERT_DELAY(lbl, a, n, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("%m: assertion failed");

`endif

[rtl/core/msgs_pkg.sv]
// ----------------------------------------------------------------------------
// msgs_pkg
// Shared constants, stage types and helpers for the sample gain pipeline.
// ----------------------------------------------------------------------------
package msgs_pkg;

    localparam int GAIN_FRAC_BITS = 24;
    localparam int SAMPLE_W       = 32;
    localparam int GAIN_W         = 32;
    localparam int FMT_W          = 3;
    localparam int CFG_IDX_W      = 1;
    localparam int PROD_W         = SAMPLE_W + GAIN_W;
    localparam int QI_W           = PROD_W - GAIN_FRAC_BITS;
    localparam int POS_W          = $clog2(PROD_W);
    localparam int MANT_W         = 24;
    localparam int FEXP_W         = 8;
    localparam int BE_W           = 10;
    // biased exponent = lead + eeff - BE_BIAS
    localparam int BE_BIAS        = (MANT_W - 1) + GAIN_FRAC_BITS;
    // right shift for subnormal results = SUB_SHIFT - eeff
    localparam int SUB_SHIFT      = 1 + GAIN_FRAC_BITS;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC_BITS - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] IDX_FMT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] IDX_GAIN = CFG_IDX_W'(1);

    // sample format codes
    localparam logic [FMT_W-1:0] FMT_S16    = FMT_W'(0);
    localparam logic [FMT_W-1:0] FMT_S24C   = FMT_W'(1);
    localparam logic [FMT_W-1:0] FMT_S24P   = FMT_W'(2);
    localparam logic [FMT_W-1:0] FMT_S32    = FMT_W'(3);
    localparam logic [FMT_W-1:0] FMT_FLOAT  = FMT_W'(4);

    // integer limits
    localparam logic [31:0] S24_SIGN_BIT  = 32'h0080_0000;
    localparam logic [31:0] S24_SIGN_FILL = 32'hFF00_0000;
    localparam logic [31:0] S24_MAX       = 32'(8388607);
    localparam logic [31:0] S24_MIN       = 32'(-8388608);
    localparam logic [31:0] S16_MAX       = 32'h0000_7FFF;
    localparam logic [31:0] S16_MIN       = 32'hFFFF_8000;
    localparam logic [31:0] S32_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN       = 32'h8000_0000;

    // IEEE single
    localparam logic [FEXP_W-1:0] F_EXP_MAX = 8'hFF;
    localparam logic [31:0]       F_QUIET   = 32'h0040_0000;
    localparam logic [31:0]       F_QNAN    = 32'h7FC0_0000;
    localparam logic [31:0]       F_INF     = 32'h7F80_0000;

    typedef enum logic [2:0] {
        KIND_DIRECT,
        KIND_S16,
        KIND_S24,
        KIND_S32,
        KIND_FLOAT
    } kind_t;

    typedef struct packed {
        logic [FMT_W-1:0]  fmt;
        logic [GAIN_W-1:0] gain;
    } cfg_t;

    typedef struct packed {
        logic              vld;
        kind_t             kind;
        logic              sign;
        logic [31:0]       opa;
        logic [FEXP_W-1:0] eeff;
        logic [31:0]       direct;
    } dec_t;

    typedef struct packed {
        logic              vld;
        kind_t             kind;
        logic              sign;
        logic [FEXP_W-1:0] eeff;
        logic [31:0]       direct;
        logic [PROD_W-1:0] prod;
    } mul_t;

    typedef struct packed {
        logic              vld;
        kind_t             kind;
        logic              sign;
        logic [FEXP_W-1:0] eeff;
        logic [31:0]       direct;
        logic [PROD_W-1:0] prod;
        logic [POS_W-1:0]  lead;
        logic [QI_W-1:0]   qint;
    } nrm_t;

    typedef struct packed {
        logic              vld;
        kind_t             kind;
        logic              sign;
        logic [31:0]       direct;
        logic [31:0]       ires;
        logic [MANT_W-1:0] fq;
        logic              rup;
        logic              ovf;
        logic [FEXP_W-1:0] fexp;
    } aln_t;

    function automatic logic [31:0] sat_hi(input kind_t k);
        case (k)
            KIND_S16: return S16_MAX;
            KIND_S24: return S24_MAX;
            default:  return S32_MAX;
        endcase
    endfunction

    function automatic logic [31:0] sat_lo(input kind_t k);
        case (k)
            KIND_S16: return S16_MIN;
            KIND_S24: return S24_MIN;
            default:  return S32_MIN;
        endcase
    endfunction

endpackage

[rtl/core/multiformat_sample_gain_saturate_top.sv]
// ----------------------------------------------------------------------------
// multiformat_sample_gain_saturate_top
// Digital gain with saturation for s16, s24 (container / packed), s32, float.
// ----------------------------------------------------------------------------
// One sample word is taken on every clock edge where start is high; busy is
// tied low, so a word may follow in the very next cycle, indefinitely. Each
// word passes the decode, multiply, norm, align and pack registers in turn
// and comes back with done high for exactly one cycle; the receiver must
// take it then, there is no hold-off. Throughput is one word per cycle,
// set by the five-stage pipeline: decode, one 32x32 multiplier, leading-one
// search / rounding add, clamp / float align,
// float round and output register. Gain is unsigned with 24 fraction bits;
// exactly unity returns every word bit-for-bit. Integer results round half
// away from zero and clamp to the format range (the 32-bit container for
// s24 clamps to 24 bits); floats round to nearest even with no clamp.
// Format codes 5 to 7 pass words through. Write sample_format (index 0)
// and gain_q8_24 (index 1) only while no word is in flight: stages read the
// live registers.
// ----------------------------------------------------------------------------
`include "multiformat_sample_gain_saturate_top_assert.svh"

module multiformat_sample_gain_saturate_top
    import msgs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [31:0]      sample_in,
    output logic                    done,
    output logic signed [31:0]      sample_out,
    input  logic                    wr_en,
    input  logic [CFG_IDX_W-1:0]    wr_index,
    input  logic [GAIN_W-1:0]       wr_data
);

    // configuration
    logic [FMT_W-1:0]  fmt_reg;
    logic [GAIN_W-1:0] gain_reg;
    cfg_t              cfg;

    // pipeline buses
    dec_t        dec_bus;
    mul_t        mul_bus;
    nrm_t        nrm_bus;
    aln_t        aln_bus;
    logic        accept;
    logic [31:0] res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_S16;
            gain_reg <= UNITY_GAIN;
        end
        else if (wr_en)
        begin
            case (wr_index)
                IDX_FMT:  fmt_reg  <= wr_data[FMT_W-1:0];
                IDX_GAIN: gain_reg <= wr_data;
                default:  ;
            endcase
        end
    end

    assign cfg.fmt  = fmt_reg;
    assign cfg.gain = gain_reg;

    // never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    msgs_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample_in (sample_in),
        .cfg       (cfg),
        .dec_out   (dec_bus)
    );

    msgs_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .dec_in  (dec_bus),
        .gain    (gain_reg),
        .mul_out (mul_bus)
    );

    msgs_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .mul_in  (mul_bus),
        .nrm_out (nrm_bus)
    );

    msgs_align u_align (
        .clk     (clk),
        .rst_n   (rst_n),
        .nrm_in  (nrm_bus),
        .aln_out (aln_bus)
    );

    msgs_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .aln_in     (aln_bus),
        .done       (done),
        .sample_out (res)
    );

    assign sample_out = res;

    // every accepted word comes out at the pipeline end, and nothing else does
    `ASSERT_DELAY(a_accept_done, accept, 5, done)
    `ASSERT_DELAY(a_idle_quiet, !accept, 5, !done)
    `ASSERT_NEXT(a_fmt_write, wr_en && wr_index == IDX_FMT, fmt_reg == $past(wr_data[FMT_W-1:0]))

endmodule

[rtl/core/msgs_decode.sv]
// ----------------------------------------------------------------------------
// msgs_decode
// Stage 1: unpacks the word per format, picks off bypass and float specials.
// ----------------------------------------------------------------------------
module msgs_decode
    import msgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [31:0] sample_in,
    input  cfg_t        cfg,
    output dec_t        dec_out
);

    dec_t              dec_reg;
    dec_t              dec_next;
    logic [31:0]       v;
    logic [31:0]       u;
    logic [FEXP_W-1:0] e;
    logic [22:0]       f;
    logic              int_fmt;

    always_comb
    begin
        dec_next        = '0;
        dec_next.vld    = accept;
        dec_next.kind   = KIND_DIRECT;
        dec_next.direct = sample_in;
        e               = sample_in[30:23];
        f               = sample_in[22:0];
        u               = sample_in & ~S24_SIGN_FILL;
        if ((u & S24_SIGN_BIT) != '0)
        begin
            u = u | S24_SIGN_FILL;
        end
        v       = sample_in;
        int_fmt = 1'b1;
        case (cfg.fmt)
            FMT_S16:
            begin
                v             = {{16{sample_in[15]}}, sample_in[15:0]};
                dec_next.kind = KIND_S16;
            end
            FMT_S24C:  dec_next.kind = KIND_S24;
            FMT_S24P:
            begin
                v             = u;
                dec_next.kind = KIND_S24;
            end
            FMT_S32:   dec_next.kind = KIND_S32;
            FMT_FLOAT: int_fmt = 1'b0;
            default:   int_fmt = 1'b0;
        endcase

        if (int_fmt)
        begin
            dec_next.sign = v[31];
            dec_next.opa  = v[31] ? (32'(0) - v) : v;
        end
        else if (cfg.fmt == FMT_FLOAT)
        begin
            dec_next.sign = sample_in[31];
            if (e == F_EXP_MAX)
            begin
                if (f != '0)
                    dec_next.direct = sample_in | F_QUIET;
                else if (cfg.gain == '0)
                    dec_next.direct = F_QNAN;
            end
            else if (cfg.gain == '0 || (e == '0 && f == '0))
            begin
                dec_next.direct = {sample_in[31], 31'b0};
            end
            else
            begin
                dec_next.kind = KIND_FLOAT;
                dec_next.opa  = {8'b0, (e != '0), f};
                dec_next.eeff = (e == '0) ? FEXP_W'(1) : e;
            end
        end

        // unity gain returns all bits untouched in every format
        if (cfg.gain == UNITY_GAIN)
        begin
            dec_next.kind   = KIND_DIRECT;
            dec_next.direct = sample_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dec_reg <= '0;
        else
            dec_reg <= dec_next;
    end

    assign dec_out = dec_reg;

endmodule

[rtl/core/msgs_mult.sv]
// ----------------------------------------------------------------------------
// msgs_mult
// Stage 2: the one 32x32 unsigned multiplier, magnitude (or mantissa) x gain.
// ----------------------------------------------------------------------------
module msgs_mult
    import msgs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dec_t              dec_in,
    input  logic [GAIN_W-1:0] gain,
    output mul_t              mul_out
);

    mul_t mul_reg;
    mul_t mul_next;

    always_comb
    begin
        mul_next.vld    = dec_in.vld;
        mul_next.kind   = dec_in.kind;
        mul_next.sign   = dec_in.sign;
        mul_next.eeff   = dec_in.eeff;
        mul_next.direct = dec_in.direct;
        mul_next.prod   = PROD_W'(dec_in.opa) * PROD_W'(gain);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_reg <= '0;
        else
            mul_reg <= mul_next;
    end

    assign mul_out = mul_reg;

endmodule

[rtl/core/msgs_norm.sv]
// ----------------------------------------------------------------------------
// msgs_norm
// Stage 3: leading-one position for float, half-up rounding add for integers.
// ----------------------------------------------------------------------------
module msgs_norm
    import msgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  mul_t mul_in,
    output nrm_t nrm_out
);

    nrm_t              nrm_reg;
    nrm_t              nrm_next;
    logic [PROD_W-1:0] rsum;

    always_comb
    begin
        nrm_next.vld    = mul_in.vld;
        nrm_next.kind   = mul_in.kind;
        nrm_next.sign   = mul_in.sign;
        nrm_next.eeff   = mul_in.eeff;
        nrm_next.direct = mul_in.direct;
        nrm_next.prod   = mul_in.prod;
        // integer products never reach the top bit, so no carry out here
        rsum            = mul_in.prod + ROUND_HALF;
        nrm_next.qint   = rsum[PROD_W-1:GAIN_FRAC_BITS];
        nrm_next.lead   = '0;
        for (int i = 0; i < PROD_W; i++)
        begin
            if (mul_in.prod[i])
                nrm_next.lead = POS_W'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nrm_reg <= '0;
        else
            nrm_reg <= nrm_next;
    end

    assign nrm_out = nrm_reg;

endmodule

[rtl/core/msgs_align.sv]
// ----------------------------------------------------------------------------
// msgs_align
// Stage 4: integer clamp; float exponent, mantissa alignment and round bits.
// ----------------------------------------------------------------------------
module msgs_align
    import msgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  nrm_t nrm_in,
    output aln_t aln_out
);

    aln_t                  aln_reg;
    aln_t                  aln_next;
    logic [31:0]           hi;
    logic [31:0]           lo;
    logic [31:0]           lomag;
    logic signed [BE_W-1:0] be;
    logic signed [BE_W-1:0] sh;
    logic [BE_W-1:0]       lsh;
    logic                  normal;
    logic                  right;
    logic [POS_W-1:0]      amt;
    logic [POS_W-1:0]      amt_m1;
    logic [PROD_W-1:0]     shifted;
    logic                  hbit;
    logic                  sticky;

    always_comb
    begin
        aln_next.vld    = nrm_in.vld;
        aln_next.kind   = nrm_in.kind;
        aln_next.sign   = nrm_in.sign;
        aln_next.direct = nrm_in.direct;

        // integer clamp
        hi    = sat_hi(nrm_in.kind);
        lo    = sat_lo(nrm_in.kind);
        lomag = 32'(0) - lo;
        if (nrm_in.sign)
            aln_next.ires = (nrm_in.qint > QI_W'(lomag)) ? lo
                                                         : (32'(0) - nrm_in.qint[31:0]);
        else
            aln_next.ires = (nrm_in.qint > QI_W'(hi)) ? hi : nrm_in.qint[31:0];

        // float exponent and shift
        be     = BE_W'(nrm_in.lead) + BE_W'(nrm_in.eeff) - BE_W'(BE_BIAS);
        normal = !be[BE_W-1] && (be != '0);
        sh     = normal ? (BE_W'(nrm_in.lead) - BE_W'(MANT_W - 1))
                        : (BE_W'(SUB_SHIFT) - BE_W'(nrm_in.eeff));
        right  = !sh[BE_W-1] && (sh != '0);
        amt    = sh[POS_W-1:0];
        amt_m1 = amt - POS_W'(1);
        lsh    = sh[BE_W-1] ? (BE_W'(0) - sh) : '0;

        if (right)
        begin
            shifted = nrm_in.prod >> amt;
            hbit    = nrm_in.prod[amt_m1];
            sticky  = (nrm_in.prod & ((PROD_W'(1) << amt_m1) - PROD_W'(1))) != '0;
        end
        else
        begin
            shifted = (lsh[BE_W-1:POS_W] == '0) ? (nrm_in.prod << lsh[POS_W-1:0]) : '0;
            hbit    = 1'b0;
            sticky  = 1'b0;
        end

        aln_next.fq   = shifted[MANT_W-1:0];
        aln_next.rup  = hbit && (sticky || shifted[0]);
        aln_next.ovf  = normal && (be[BE_W-2:0] >= (BE_W-1)'(F_EXP_MAX));
        aln_next.fexp = normal ? FEXP_W'(be - BE_W'(1)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            aln_reg <= '0;
        else
            aln_reg <= aln_next;
    end

    assign aln_out = aln_reg;

endmodule

[rtl/core/msgs_pack.sv]
// ----------------------------------------------------------------------------
// msgs_pack
// Stage 5: float round-up and exponent merge, result select, output register.
// ----------------------------------------------------------------------------
`include "multiformat_sample_gain_saturate_top_assert.svh"

module msgs_pack
    import msgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  aln_t        aln_in,
    output logic        done,
    output logic [31:0] sample_out
);

    logic        done_reg;
    logic [31:0] res_reg;
    logic [31:0] res_next;
    logic [31:0] fsum;
    logic [31:0] fres;
    logic        s16_fits;
    logic        s24_fits;

    always_comb
    begin
        // mantissa carry ripples into the exponent on its own
        fsum = 32'(aln_in.fq) + 32'(aln_in.rup) + {1'b0, aln_in.fexp, 23'b0};
        if (aln_in.ovf || fsum >= F_INF)
            fres = {aln_in.sign, F_INF[30:0]};
        else
            fres = {aln_in.sign, fsum[30:0]};

        case (aln_in.kind)
            KIND_DIRECT: res_next = aln_in.direct;
            KIND_FLOAT:  res_next = fres;
            default:     res_next = aln_in.ires;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= aln_in.vld;
            res_reg  <= res_next;
        end
    end

    assign done       = done_reg;
    assign sample_out = res_reg;

    // sign extension intact above the 16 / 24 bit range
    assign s16_fits = (sample_out[31:15] == '0) || (sample_out[31:15] == '1);
    assign s24_fits = (sample_out[31:23] == '0) || (sample_out[31:23] == '1);

    `ASSERT_NEXT(a_s16_range, aln_in.vld && aln_in.kind == KIND_S16, s16_fits)
    `ASSERT_NEXT(a_s24_range, aln_in.vld && aln_in.kind == KIND_S24, s24_fits)
    `ASSERT_NEXT(a_float_ovf, aln_in.vld && aln_in.kind == KIND_FLOAT && aln_in.ovf, sample_out[30:0] == F_INF[30:0])

endmodule
